[hdl/assert_macros.svh]
// Assertion macros shared by the RTL, compiled out when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLIES(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (expr)) \
        else $error("Assertion failed.");
`define ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (expr)) \
        else $error("Assertion failed.");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, cond, expr)
`define ASSERT_NEXT(label, clk, rst_n, cond, expr)
`endif
`endif

[hdl/lrup_pkg.sv]
// Package with the transaction types and constants of the LRU page cache.
`timescale 1ns / 1ps
package lrup_pkg;

    localparam int WAYS_DEFAULT      = 8;
    localparam int PAGE_BITS_DEFAULT = 16;
    localparam int AGE_BITS_DEFAULT  = 16;

    localparam int PAGE_W  = 16;
    localparam int WAY_W   = 3;
    localparam int TOTAL_W = 32;
    localparam int CFG_W   = 4;

    localparam int AGE_RESET = 100;
    localparam int AGE_FRESH = 1;

    localparam logic [CFG_W-1:0] WAYS_IN_USE_RESET = CFG_W'(8);

    // Queue depth must be a power of two so the pointers wrap on their own.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [PAGE_W-1:0] page_number;
        logic              last_request;
    } t_req;

    typedef struct packed {
        logic               hit;
        logic [WAY_W-1:0]   way;
        logic [PAGE_W-1:0]  evicted_page;
        logic [TOTAL_W-1:0] hit_total;
        logic [TOTAL_W-1:0] miss_total;
    } t_rsp;

endpackage

[hdl/lrup_front.sv]
// Front end: accepts page references, truncates or zero-extends them to the page width and queues them.
`timescale 1ns / 1ps
module lrup_front #(
    parameter int PAGE_BITS = lrup_pkg::PAGE_BITS_DEFAULT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    input  lrup_pkg::t_req       i_req,
    output logic                 busy,
    input  logic                 i_pop,
    output logic                 o_valid,
    output logic [PAGE_BITS-1:0] o_page,
    output logic                 o_last
);

    localparam int WIDE_W = (PAGE_BITS > lrup_pkg::PAGE_W) ? PAGE_BITS : lrup_pkg::PAGE_W;

    logic [PAGE_BITS-1:0]        r_q_page [lrup_pkg::QUEUE_DEPTH];
    logic                        r_q_last [lrup_pkg::QUEUE_DEPTH];
    logic [lrup_pkg::QPTR_W-1:0] r_wp, n_wp;
    logic [lrup_pkg::QPTR_W-1:0] r_rp, n_rp;
    logic [lrup_pkg::QCNT_W-1:0] r_cnt, n_cnt;
    logic [WIDE_W-1:0]           w_page_wide;
    logic                        w_push;
    logic                        w_pop;

    assign busy        = (r_cnt == lrup_pkg::QCNT_W'(lrup_pkg::QUEUE_DEPTH));
    assign w_push      = start && !busy;
    assign o_valid     = (r_cnt != '0);
    assign w_pop       = o_valid && i_pop;
    assign w_page_wide = WIDE_W'(i_req.page_number);
    assign o_page      = r_q_page[r_rp];
    assign o_last      = r_q_last[r_rp];

    always_comb begin
        n_wp  = w_push ? r_wp + 1'b1 : r_wp;
        n_rp  = w_pop ? r_rp + 1'b1 : r_rp;
        n_cnt = r_cnt;
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (w_pop && !w_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q_page[r_wp] <= w_page_wide[PAGE_BITS-1:0];
            r_q_last[r_wp] <= i_req.last_request;
        end
    end

endmodule

[hdl/lrup_back.sv]
// Back end: tag lookup, LRU victim choice, way and age update and running totals.
`timescale 1ns / 1ps
module lrup_back #(
    parameter int WAYS      = lrup_pkg::WAYS_DEFAULT,
    parameter int PAGE_BITS = lrup_pkg::PAGE_BITS_DEFAULT,
    parameter int AGE_BITS  = lrup_pkg::AGE_BITS_DEFAULT
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [PAGE_BITS-1:0]       i_page,
    input  logic                       i_last,
    input  logic [lrup_pkg::CFG_W-1:0] i_ways_in_use,
    output logic                       o_pop,
    output logic                       o_strobe,
    output lrup_pkg::t_rsp             o_rsp
);

    localparam int IDX_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int ACT_W    = $clog2(WAYS + 1);
    localparam int WPAGE_W  = (PAGE_BITS > lrup_pkg::PAGE_W) ? PAGE_BITS : lrup_pkg::PAGE_W;
    localparam int WWAY_W   = (IDX_W > lrup_pkg::WAY_W) ? IDX_W : lrup_pkg::WAY_W;
    localparam logic [AGE_BITS-1:0] AGE_MAX   = {AGE_BITS{1'b1}};
    localparam logic [AGE_BITS-1:0] AGE_INIT  = AGE_BITS'(lrup_pkg::AGE_RESET);
    localparam logic [AGE_BITS-1:0] AGE_NEW   = AGE_BITS'(lrup_pkg::AGE_FRESH);
    localparam logic [lrup_pkg::TOTAL_W-1:0] TOTAL_MAX = {lrup_pkg::TOTAL_W{1'b1}};

    logic [PAGE_BITS-1:0]          r_pages [WAYS];
    logic [PAGE_BITS-1:0]          n_pages [WAYS];
    logic [AGE_BITS-1:0]           r_ages  [WAYS];
    logic [AGE_BITS-1:0]           n_ages  [WAYS];
    logic [lrup_pkg::TOTAL_W-1:0]  r_hit_cnt, n_hit_cnt;
    logic [lrup_pkg::TOTAL_W-1:0]  r_miss_cnt, n_miss_cnt;
    logic                          r_strobe;
    lrup_pkg::t_rsp                r_rsp, n_rsp;

    logic [ACT_W-1:0]              w_active_n;
    logic [WAYS-1:0]               w_act;
    logic [WAYS-1:0]               w_match;
    logic                          w_hit;
    logic [IDX_W-1:0]              w_hit_idx;
    logic [IDX_W-1:0]              w_vic_idx;
    logic [IDX_W-1:0]              w_sel;
    logic [AGE_BITS-1:0]           w_best;
    logic [lrup_pkg::TOTAL_W-1:0]  w_hit_tot;
    logic [lrup_pkg::TOTAL_W-1:0]  w_miss_tot;
    logic [WPAGE_W-1:0]            w_evict_wide;
    logic [WWAY_W-1:0]             w_way_wide;

    assign o_pop    = i_valid;
    assign o_strobe = r_strobe;
    assign o_rsp    = r_rsp;

    always_comb begin
        if (i_ways_in_use == '0) begin
            w_active_n = ACT_W'(1);
        end else if (32'(i_ways_in_use) > WAYS) begin
            w_active_n = ACT_W'(WAYS);
        end else begin
            w_active_n = ACT_W'(i_ways_in_use);
        end
    end

    always_comb begin
        for (int i = 0; i < WAYS; i++) begin
            w_act[i]   = (ACT_W'(i) < w_active_n);
            w_match[i] = w_act[i] && (r_pages[i] == i_page);
        end
        w_hit = |w_match;

        w_hit_idx = '0;
        for (int i = WAYS - 1; i >= 0; i--) begin
            if (w_match[i]) begin
                w_hit_idx = IDX_W'(i);
            end
        end

        w_best    = r_ages[0];
        w_vic_idx = '0;
        for (int i = 1; i < WAYS; i++) begin
            if (w_act[i] && (r_ages[i] > w_best)) begin
                w_best    = r_ages[i];
                w_vic_idx = IDX_W'(i);
            end
        end

        w_sel = w_hit ? w_hit_idx : w_vic_idx;

        for (int i = 0; i < WAYS; i++) begin
            n_pages[i] = r_pages[i];
            n_ages[i]  = (r_ages[i] == AGE_MAX) ? r_ages[i] : r_ages[i] + 1'b1;
            if (IDX_W'(i) == w_sel) begin
                n_ages[i] = AGE_NEW;
                if (!w_hit) begin
                    n_pages[i] = i_page;
                end
            end
        end

        w_hit_tot  = r_hit_cnt;
        w_miss_tot = r_miss_cnt;
        if (w_hit) begin
            if (r_hit_cnt != TOTAL_MAX) begin
                w_hit_tot = r_hit_cnt + 1'b1;
            end
        end else if (r_miss_cnt != TOTAL_MAX) begin
            w_miss_tot = r_miss_cnt + 1'b1;
        end
        n_hit_cnt  = i_last ? '0 : w_hit_tot;
        n_miss_cnt = i_last ? '0 : w_miss_tot;

        w_evict_wide = w_hit ? '0 : WPAGE_W'(r_pages[w_vic_idx]);
        w_way_wide   = WWAY_W'(w_sel);

        n_rsp.hit          = w_hit;
        n_rsp.way          = w_way_wide[lrup_pkg::WAY_W-1:0];
        n_rsp.evicted_page = w_evict_wide[lrup_pkg::PAGE_W-1:0];
        n_rsp.hit_total    = w_hit_tot;
        n_rsp.miss_total   = w_miss_tot;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WAYS; i++) begin
                r_pages[i] <= '0;
                r_ages[i]  <= AGE_INIT;
            end
            r_hit_cnt  <= '0;
            r_miss_cnt <= '0;
            r_strobe   <= 1'b0;
        end else begin
            r_strobe <= i_valid;
            if (i_valid) begin
                for (int i = 0; i < WAYS; i++) begin
                    r_pages[i] <= n_pages[i];
                    r_ages[i]  <= n_ages[i];
                end
                r_hit_cnt  <= n_hit_cnt;
                r_miss_cnt <= n_miss_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_rsp <= n_rsp;
        end
    end

endmodule

[hdl/lru_page_replacement.sv]
// Top level of the fully associative LRU page cache.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// A page reference is taken at a rising edge with start high and busy low. It enters
// a two-entry queue and is looked up in the cycle right after acceptance. Its result
// is registered at the next edge and stays on o_rsp with o_strobe high for exactly one
// cycle. The lookup unit retires one reference every cycle. That rate is set by its
// combinational tag compare and age maximum across all ways. The queue therefore
// never holds more than one reference, busy stays low, and one reference per cycle
// is sustained. The receiver cannot stall: a result must be taken in the cycle its
// strobe is high. The way count register may be written only while no reference is
// in flight. After reset all ways hold page 0 with age 100 and the block is ready
// at once.
module lru_page_replacement #(
    parameter int WAYS      = lrup_pkg::WAYS_DEFAULT,
    parameter int PAGE_BITS = lrup_pkg::PAGE_BITS_DEFAULT,
    parameter int AGE_BITS  = lrup_pkg::AGE_BITS_DEFAULT
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    input  lrup_pkg::t_req             i_req,
    output logic                       busy,
    input  logic                       i_cfg_we,
    input  logic [lrup_pkg::CFG_W-1:0] i_cfg_wdata,
    output logic                       o_strobe,
    output lrup_pkg::t_rsp             o_rsp
);

    logic [lrup_pkg::CFG_W-1:0] r_ways_in_use;
    logic                       w_q_valid;
    logic                       w_q_pop;
    logic [PAGE_BITS-1:0]       w_q_page;
    logic                       w_q_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ways_in_use <= lrup_pkg::WAYS_IN_USE_RESET;
        end else if (i_cfg_we) begin
            r_ways_in_use <= i_cfg_wdata;
        end
    end

    lrup_front #(
        .PAGE_BITS (PAGE_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_req   (i_req),
        .busy    (busy),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_page  (w_q_page),
        .o_last  (w_q_last)
    );

    lrup_back #(
        .WAYS      (WAYS),
        .PAGE_BITS (PAGE_BITS),
        .AGE_BITS  (AGE_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_q_valid),
        .i_page        (w_q_page),
        .i_last        (w_q_last),
        .i_ways_in_use (r_ways_in_use),
        .o_pop         (w_q_pop),
        .o_strobe      (o_strobe),
        .o_rsp         (o_rsp)
    );

    `ASSERT_NEXT(a_accept_queued, i_clk, i_rst_n, start && !busy, w_q_valid)
    `ASSERT_NEXT(a_queue_retired, i_clk, i_rst_n, w_q_valid, o_strobe)
    `ASSERT_IMPLIES(a_hit_no_evict, i_clk, i_rst_n, o_strobe && o_rsp.hit, o_rsp.evicted_page == '0)
    `ASSERT_IMPLIES(a_hit_counted, i_clk, i_rst_n, o_strobe && o_rsp.hit, o_rsp.hit_total != '0)

endmodule
